/* design/ms_pkg.sv */
// ms_pkg: shared widths, item types and RAM request struct for the merge sorter.
// No dependencies; used by ms_ram, merge_sorter and ms_checker.
package ms_pkg;

    localparam int MAX_ITEMS = 64;                       // set capacity, at most 64 values per set
    localparam int IDX_W     = $clog2(MAX_ITEMS + 1);    // holds 0..MAX_ITEMS
    localparam int ADDR_W    = $clog2(MAX_ITEMS);        // memory address
    localparam int SUM_W     = IDX_W + 1;                // index sums before clamping
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     overflow;
    } t_out_item;

    // one write port, two read ports
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

endpackage

/* design/ms_ram.sv */
// ms_ram: element memory with one write port and two registered read ports.
// Depends on ms_pkg for widths and the request struct.
module ms_ram (
    input  logic                        i_clk,
    input  ms_pkg::t_ram_req            i_req,
    output logic [ms_pkg::DATA_W-1:0]   o_rdata_a,
    output logic [ms_pkg::DATA_W-1:0]   o_rdata_b
);

    logic [ms_pkg::DATA_W-1:0] mem [2**ms_pkg::ADDR_W];
    logic [ms_pkg::DATA_W-1:0] r_rdata_a;
    logic [ms_pkg::DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata_a <= mem[i_req.raddr_a];
        r_rdata_b <= mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* design/merge_sorter.sv */
// merge_sorter: top level of the bottom-up merge sorter.
// Depends on ms_pkg and ms_ram (two instances, used ping-pong).
//
// Values arrive one item per cycle and are written to memory 0 until an item with
// last set; up to MAX_ITEMS values are kept, the rest are dropped and every result
// of that set then carries overflow. The input stalls from the last item until the
// final result has been taken. Sorting runs ceil(log2(n)) merge passes over the n
// stored values, each pass reading one memory on two ports (left and right run heads)
// and writing the other through its single write port; each pass first primes the
// run heads in ST_PRIME, then writes one element per cycle. ST_OPRIME then primes
// the output read, after which results stream at one per cycle unless stalled.
// No clearing pass is needed after reset.
module merge_sorter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  ms_pkg::t_in_item  i_item,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output ms_pkg::t_out_item o_item
);

    localparam int IDX_W  = ms_pkg::IDX_W;
    localparam int ADDR_W = ms_pkg::ADDR_W;
    localparam int SUM_W  = ms_pkg::SUM_W;
    localparam int DATA_W = ms_pkg::DATA_W;

    localparam logic [2:0] ST_LOAD   = 3'd0;   // collecting values
    localparam logic [2:0] ST_PRIME  = 3'd1;   // fetch first run heads of a pass
    localparam logic [2:0] ST_MERGE  = 3'd2;   // one element merged per cycle
    localparam logic [2:0] ST_OPRIME = 3'd3;   // fetch first sorted element
    localparam logic [2:0] ST_OUT    = 3'd4;   // stream results

    localparam logic [IDX_W-1:0] CAP = IDX_W'(ms_pkg::MAX_ITEMS);

    // clamp a run boundary to the set size
    function automatic logic [IDX_W-1:0] f_clamp(input logic [SUM_W-1:0] s,
                                                 input logic [IDX_W-1:0] n);
        return (s > {1'b0, n}) ? n : s[IDX_W-1:0];
    endfunction

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt,   n_cnt;     // stored elements (n during sort/output)
    logic             r_drop,  n_drop;
    logic             r_src,   n_src;     // memory holding the current runs
    logic [IDX_W-1:0] r_w,     n_w;       // run width of this pass
    logic [IDX_W-1:0] r_i,     n_i;       // left run head
    logic [IDX_W-1:0] r_j,     n_j;       // right run head
    logic [IDX_W-1:0] r_mid,   n_mid;     // end of left run
    logic [IDX_W-1:0] r_end,   n_end;     // end of right run
    logic [IDX_W-1:0] r_k,     n_k;       // write / output index

    ms_pkg::t_ram_req  req0, req1;
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic signed [DATA_W-1:0] q_a, q_b;

    // write port shared by load and merge, routed to one memory
    logic              wr_en;
    logic              wr_sel;            // 0: memory 0, 1: memory 1
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_a_idx, rd_b_idx;

    logic             accept;
    logic [IDX_W-1:0] cnt_after;
    logic             left_done, right_done, take_left;
    logic [SUM_W-1:0] w_dbl;
    logic [IDX_W-1:0] nxt_i, nxt_j;
    logic             out_last;

    ms_ram u_ram0 (.i_clk(i_clk), .i_req(req0), .o_rdata_a(rd0_a), .o_rdata_b(rd0_b));
    ms_ram u_ram1 (.i_clk(i_clk), .i_req(req1), .o_rdata_a(rd1_a), .o_rdata_b(rd1_b));

    // both memories are read at the same addresses; r_src picks the live one
    assign q_a = r_src ? rd1_a : rd0_a;
    assign q_b = r_src ? rd1_b : rd0_b;

    assign o_stall  = (r_state != ST_LOAD);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = (r_state == ST_OUT);
    assign out_last = (r_k + IDX_W'(1)) == r_cnt;

    assign o_item.value_res = q_a;
    assign o_item.last_res  = out_last;
    assign o_item.overflow  = r_drop;

    // merge decision: equal heads take the left run (stable order)
    assign left_done  = (r_i >= r_mid);
    assign right_done = (r_j >= r_end);
    assign take_left  = !left_done && (right_done || !(q_b < q_a));
    assign nxt_i      = take_left ? r_i + IDX_W'(1) : r_i;
    assign nxt_j      = take_left ? r_j : r_j + IDX_W'(1);
    assign w_dbl      = SUM_W'(r_w) << 1;
    assign cnt_after  = (r_cnt < CAP) ? r_cnt + IDX_W'(1) : r_cnt;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_src    = r_src;
        n_w      = r_w;
        n_i      = r_i;
        n_j      = r_j;
        n_mid    = r_mid;
        n_end    = r_end;
        n_k      = r_k;
        wr_en    = 1'b0;
        wr_sel   = 1'b0;
        wr_addr  = r_cnt[ADDR_W-1:0];
        wr_data  = i_item.value;
        rd_a_idx = r_i;
        rd_b_idx = r_j;

        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (r_cnt < CAP) begin
                        wr_en = 1'b1;
                        n_cnt = cnt_after;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_item.last) begin
                        n_src   = 1'b0;
                        n_w     = IDX_W'(1);
                        n_state = (cnt_after > IDX_W'(1)) ? ST_PRIME : ST_OPRIME;
                    end
                end
            end
            ST_PRIME: begin
                n_i      = '0;
                n_k      = '0;
                n_mid    = f_clamp(SUM_W'(r_w), r_cnt);
                n_end    = f_clamp(w_dbl, r_cnt);
                n_j      = n_mid;
                rd_a_idx = '0;
                rd_b_idx = n_mid;
                n_state  = ST_MERGE;
            end
            ST_MERGE: begin
                wr_en   = 1'b1;
                wr_sel  = ~r_src;
                wr_addr = r_k[ADDR_W-1:0];
                wr_data = take_left ? q_a : q_b;
                if ((r_k + IDX_W'(1)) == r_end) begin
                    if (r_end == r_cnt) begin
                        // pass done: written memory becomes the source
                        n_w     = w_dbl[IDX_W-1:0];
                        n_src   = ~r_src;
                        n_state = (w_dbl >= SUM_W'(r_cnt)) ? ST_OPRIME : ST_PRIME;
                    end else begin
                        // next pair of runs, no bubble
                        n_i      = r_end;
                        n_k      = r_end;
                        n_mid    = f_clamp(SUM_W'(r_end) + SUM_W'(r_w), r_cnt);
                        n_end    = f_clamp(SUM_W'(r_end) + w_dbl, r_cnt);
                        n_j      = n_mid;
                        rd_a_idx = r_end;
                        rd_b_idx = n_mid;
                    end
                end else begin
                    n_i      = nxt_i;
                    n_j      = nxt_j;
                    n_k      = r_k + IDX_W'(1);
                    rd_a_idx = nxt_i;
                    rd_b_idx = nxt_j;
                end
            end
            ST_OPRIME: begin
                n_k      = '0;
                rd_a_idx = '0;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                // re-read the same entry while stalled so the result holds
                rd_a_idx = r_k;
                if (!i_stall) begin
                    if (out_last) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k      = r_k + IDX_W'(1);
                        rd_a_idx = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        req0.we      = wr_en && !wr_sel;
        req0.waddr   = wr_addr;
        req0.wdata   = wr_data;
        req0.raddr_a = rd_a_idx[ADDR_W-1:0];
        req0.raddr_b = rd_b_idx[ADDR_W-1:0];
        req1.we      = wr_en && wr_sel;
        req1.waddr   = wr_addr;
        req1.wdata   = wr_data;
        req1.raddr_a = rd_a_idx[ADDR_W-1:0];
        req1.raddr_b = rd_b_idx[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_src   <= 1'b0;
            r_w     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_mid   <= '0;
            r_end   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_src   <= n_src;
            r_w     <= n_w;
            r_i     <= n_i;
            r_j     <= n_j;
            r_mid   <= n_mid;
            r_end   <= n_end;
            r_k     <= n_k;
        end
    end

endmodule

/* design/ms_checker.sv */
// ms_checker: port-level assertions for merge_sorter, attached by bind.
// Depends on ms_pkg for the item types.
module ms_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input ms_pkg::t_in_item  i_item,
    input logic              o_valid,
    input logic              i_stall,
    input ms_pkg::t_out_item o_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("result changed while stalled");

    // no loading while results stream
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && !o_stall))
        else $error("input taken during output");

    // last input starts the sort, input closes
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_item.last) |=> o_stall)
        else $error("input still open after last item");

    // set ends after its final result
    a_set_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_item.last_res) |=> (!o_valid && !o_stall))
        else $error("output continued past final result");

    // overflow constant across one set's results
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid)) |-> $stable(o_item.overflow))
        else $error("overflow flag changed within a set");

endmodule

bind merge_sorter ms_checker u_ms_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
